FILE: rtl/crs_pkg.sv
// Shared types, register codes and constants of the climate relay scheduler.
`timescale 1ns / 1ps
`default_nettype none

package crs_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_HUM_LOW    = 3'd0;
	localparam logic [2:0] REG_HUM_HIGH   = 3'd1;
	localparam logic [2:0] REG_FAN_ON     = 3'd2;
	localparam logic [2:0] REG_FAN_OFF    = 3'd3;
	localparam logic [2:0] REG_LIGHT_WIN  = 3'd4;
	localparam logic [2:0] REG_AUX_WIN    = 3'd5;
	localparam logic [2:0] REG_FOG_WIN    = 3'd6;
	localparam logic [2:0] REG_FOG_TIMING = 3'd7;

	// Reset values of the registers
	localparam logic [9:0]         RST_HUM_LOW    = 10'd600;
	localparam logic [9:0]         RST_HUM_HIGH   = 10'd800;
	localparam logic signed [11:0] RST_FAN_ON     = 12'sd300;
	localparam logic signed [11:0] RST_FAN_OFF    = 12'sd280;
	localparam logic [9:0]         RST_WINDOW     = 10'd648;
	localparam logic [23:0]        RST_FOG_TIMING = 24'd7682;

	// Time scale factors
	localparam logic [31:0] MS_PER_HOUR   = 32'd3600000;
	localparam logic [31:0] MS_PER_SECOND = 32'd1000;

	// Auto enable bit positions
	localparam int AUTO_FOG   = 0;
	localparam int AUTO_FAN   = 1;
	localparam int AUTO_LIGHT = 2;
	localparam int AUTO_AUX   = 3;

	typedef struct packed {
		logic [9:0]         hum_low;
		logic [9:0]         hum_high;
		logic signed [11:0] fan_on;
		logic signed [11:0] fan_off;
		logic [9:0]         light_win;
		logic [9:0]         aux_win;
		logic [9:0]         fog_win;
		logic [23:0]        fog_timing;
	} cfg_t;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic [4:0]         hour_of_day;
		logic               clock_valid;
		logic               sensor_valid;
		logic [9:0]         humidity;
		logic signed [11:0] temperature;
		logic [3:0]         auto_enables;
	} tick_t;

	typedef struct packed {
		logic fog_write;
		logic fog_on;
		logic fan_write;
		logic fan_on;
		logic light_write;
		logic light_on;
		logic aux_write;
		logic aux_on;
		logic humidity_request;
		logic temperature_request;
	} result_t;

	// Hour window: active from on hour up to, not including, off hour
	function automatic logic in_window(input logic [4:0] hour, input logic [9:0] win);
		in_window = (hour >= win[4:0]) && (hour < win[9:5]);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/crs_cfg_regs.sv
// Configuration register file of the climate relay scheduler.
`timescale 1ns / 1ps
`default_nettype none

module crs_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_wr_en,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [23:0]   cfg_wdata,
	output crs_pkg::cfg_t      cfg
);
	import crs_pkg::*;

	cfg_t cfg_q;

	// Decode the index and capture the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hum_low    <= RST_HUM_LOW;
			cfg_q.hum_high   <= RST_HUM_HIGH;
			cfg_q.fan_on     <= RST_FAN_ON;
			cfg_q.fan_off    <= RST_FAN_OFF;
			cfg_q.light_win  <= RST_WINDOW;
			cfg_q.aux_win    <= RST_WINDOW;
			cfg_q.fog_win    <= RST_WINDOW;
			cfg_q.fog_timing <= RST_FOG_TIMING;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_HUM_LOW:    cfg_q.hum_low    <= cfg_wdata[9:0];
				REG_HUM_HIGH:   cfg_q.hum_high   <= cfg_wdata[9:0];
				REG_FAN_ON:     cfg_q.fan_on     <= signed'(cfg_wdata[11:0]);
				REG_FAN_OFF:    cfg_q.fan_off    <= signed'(cfg_wdata[11:0]);
				REG_LIGHT_WIN:  cfg_q.light_win  <= cfg_wdata[9:0];
				REG_AUX_WIN:    cfg_q.aux_win    <= cfg_wdata[9:0];
				REG_FOG_WIN:    cfg_q.fog_win    <= cfg_wdata[9:0];
				REG_FOG_TIMING: cfg_q.fog_timing <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/crs_core.sv
// Per-tick relay decision logic and scheduler state of the climate relay scheduler.
`timescale 1ns / 1ps
`default_nettype none

module crs_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire crs_pkg::cfg_t cfg,
	input  wire crs_pkg::tick_t tick,
	input  wire logic          commit,
	output crs_pkg::result_t   res
);
	import crs_pkg::*;

	logic        fog_req_q, fan_req_q, light_prev_q, aux_prev_q;
	logic        fog_run_q, fog_prev_set_q;
	logic [31:0] fog_begin_q, fog_prev_run_q;

	logic        fog_req_d, fan_req_d, light_prev_d, aux_prev_d;
	logic        fog_run_d, fog_prev_set_d;
	logic [31:0] fog_begin_d, fog_prev_run_d;

	logic [31:0] interval, duration;
	logic [31:0] since_run, since_begin;
	logic        want_light, want_aux, fog_active, fog_start, fog_due;
	logic        light_en, aux_en, fog_en;

	// Scale the fog timing fields to milliseconds
	assign interval    = {24'd0, cfg.fog_timing[7:0]} * MS_PER_HOUR;
	assign duration    = {16'd0, cfg.fog_timing[23:8]} * MS_PER_SECOND;
	assign since_run   = tick.now_ms - fog_prev_run_q;
	assign since_begin = tick.now_ms - fog_begin_q;

	assign want_light = in_window(tick.hour_of_day, cfg.light_win);
	assign want_aux   = in_window(tick.hour_of_day, cfg.aux_win);
	assign fog_active = in_window(tick.hour_of_day, cfg.fog_win);

	assign light_en = tick.clock_valid && tick.auto_enables[AUTO_LIGHT];
	assign aux_en   = tick.clock_valid && tick.auto_enables[AUTO_AUX];
	assign fog_en   = tick.clock_valid && tick.auto_enables[AUTO_FOG];

	// Start a fog cycle; an unset last-run time counts as one interval ago
	assign fog_due   = !fog_prev_set_q || (since_run >= interval);
	assign fog_start = fog_en && fog_active && !fog_run_q && fog_req_d && fog_due;

	// Next state and result of this tick
	always_comb begin
		fog_req_d      = fog_req_q;
		fan_req_d      = fan_req_q;
		light_prev_d   = light_prev_q;
		aux_prev_d     = aux_prev_q;
		fog_run_d      = fog_run_q;
		fog_prev_set_d = fog_prev_set_q;
		fog_begin_d    = fog_begin_q;
		fog_prev_run_d = fog_prev_run_q;
		res            = '0;

		// Hysteresis requests
		if (!tick.sensor_valid) begin
			fog_req_d = 1'b0;
			fan_req_d = 1'b0;
		end else begin
			if (!fog_req_q) begin
				if (tick.humidity <= cfg.hum_low) fog_req_d = 1'b1;
			end else if (tick.humidity >= cfg.hum_high) begin
				fog_req_d = 1'b0;
			end
			if (!fan_req_q) begin
				if (tick.temperature >= cfg.fan_on) fan_req_d = 1'b1;
			end else if (tick.temperature <= cfg.fan_off) begin
				fan_req_d = 1'b0;
			end
		end

		// Light on window change
		if (light_en && (want_light != light_prev_q)) begin
			light_prev_d    = want_light;
			res.light_write = 1'b1;
			res.light_on    = want_light;
		end

		// Fog cycle scheduling
		if (fog_en) begin
			fog_prev_set_d = 1'b1;
			if (!fog_prev_set_q) fog_prev_run_d = tick.now_ms - interval;
			if (fog_active) begin
				if (fog_start) begin
					fog_begin_d    = tick.now_ms;
					fog_prev_run_d = tick.now_ms;
					res.fog_write  = 1'b1;
					res.fog_on     = 1'b1;
					fog_run_d      = 1'b1;
					// a zero duration ends the cycle in the same tick
					if (duration == 32'd0) begin
						res.fog_on = 1'b0;
						fog_run_d  = 1'b0;
					end
				end else if (fog_run_q && (since_begin >= duration)) begin
					res.fog_write = 1'b1;
					res.fog_on    = 1'b0;
					fog_run_d     = 1'b0;
				end
			end else if (fog_run_q) begin
				res.fog_write = 1'b1;
				res.fog_on    = 1'b0;
				fog_run_d     = 1'b0;
			end
		end

		// Fan follows its request
		if (tick.auto_enables[AUTO_FAN]) begin
			res.fan_write = 1'b1;
			res.fan_on    = fan_req_d;
		end

		// Aux on window change
		if (aux_en && (want_aux != aux_prev_q)) begin
			aux_prev_d    = want_aux;
			res.aux_write = 1'b1;
			res.aux_on    = want_aux;
		end

		res.humidity_request    = fog_req_d;
		res.temperature_request = fan_req_d;
	end

	// Commit the state when the tick moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fog_req_q      <= 1'b0;
			fan_req_q      <= 1'b0;
			light_prev_q   <= 1'b0;
			aux_prev_q     <= 1'b0;
			fog_run_q      <= 1'b0;
			fog_prev_set_q <= 1'b0;
			fog_begin_q    <= '0;
			fog_prev_run_q <= '0;
		end else if (commit) begin
			fog_req_q      <= fog_req_d;
			fan_req_q      <= fan_req_d;
			light_prev_q   <= light_prev_d;
			aux_prev_q     <= aux_prev_d;
			fog_run_q      <= fog_run_d;
			fog_prev_set_q <= fog_prev_set_d;
			fog_begin_q    <= fog_begin_d;
			fog_prev_run_q <= fog_prev_run_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/climate_relay_scheduler_unit.sv
// Top level of the climate relay scheduler: input register, decision logic, result register.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  in       | in_valid / in_ready    | now_ms .. auto_enables, one tick
//  out      | out_valid / out_ready  | relay write/value bits and requests
//  cfg      | cfg_wr_en              | cfg_index, cfg_wdata (no wait)
//
// One tick per cycle sustained while the output is not stalled; a tick passes
// through the input register and then the result register to the output.
// Scheduler state updates as a tick leaves the input register, so the next
// tick sees it. A stalled output holds both registers; in_ready drops only
// when the input register is full and cannot move on. Reset empties both
// stages and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module climate_relay_scheduler_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [31:0]        now_ms,
	input  wire logic [4:0]         hour_of_day,
	input  wire logic               clock_valid,
	input  wire logic               sensor_valid,
	input  wire logic [9:0]         humidity,
	input  wire logic signed [11:0] temperature,
	input  wire logic [3:0]         auto_enables,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    fog_write,
	output logic                    fog_on,
	output logic                    fan_write,
	output logic                    fan_on,
	output logic                    light_write,
	output logic                    light_on,
	output logic                    aux_write,
	output logic                    aux_on,
	output logic                    humidity_request,
	output logic                    temperature_request,
	input  wire logic               cfg_wr_en,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [23:0]        cfg_wdata
);
	import crs_pkg::*;

	cfg_t    cfg;
	tick_t   tick_s1;
	result_t res, res_s2;
	logic    valid_s1, valid_s2, advance;

	crs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Move the tick on when the result register is free or drains
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tick_s1 <= '{now_ms, hour_of_day, clock_valid, sensor_valid,
				humidity, temperature, auto_enables};
		end
	end

	crs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.tick   (tick_s1),
		.commit (advance),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res;
	end

	assign out_valid           = valid_s2;
	assign fog_write           = res_s2.fog_write;
	assign fog_on              = res_s2.fog_on;
	assign fan_write           = res_s2.fan_write;
	assign fan_on              = res_s2.fan_on;
	assign light_write         = res_s2.light_write;
	assign light_on            = res_s2.light_on;
	assign aux_write           = res_s2.aux_write;
	assign aux_on              = res_s2.aux_on;
	assign humidity_request    = res_s2.humidity_request;
	assign temperature_request = res_s2.temperature_request;

endmodule

`default_nettype wire
